FILE: src/rgb2i420_pkg.sv
// Shared types, coefficients and helpers for the RGB565 to I420 converter.
package rgb2i420_pkg;

    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_W      = 11;
    localparam int COL_W      = 11;
    localparam int PIX_W      = 16;
    localparam int SUM_W      = 17;
    localparam int LOFF_W     = 22;
    localparam int COFF_W     = 23;
    localparam int PROD_W     = 24;

    localparam logic [CFG_W-1:0] MAX_WIDTH    = 12'd2048;
    localparam logic [CFG_W-1:0] MAX_HEIGHT   = 12'd2048;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd320;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd240;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [SUM_W-1:0] COEF_YR = 17'd66;
    localparam logic [SUM_W-1:0] COEF_YG = 17'd129;
    localparam logic [SUM_W-1:0] COEF_YB = 17'd25;
    localparam logic [SUM_W-1:0] COEF_UR = 17'd38;
    localparam logic [SUM_W-1:0] COEF_UG = 17'd74;
    localparam logic [SUM_W-1:0] COEF_UB = 17'd112;
    localparam logic [SUM_W-1:0] COEF_VR = 17'd112;
    localparam logic [SUM_W-1:0] COEF_VG = 17'd94;
    localparam logic [SUM_W-1:0] COEF_VB = 17'd18;
    localparam logic [SUM_W-1:0] Y_ROUND     = 17'd128;
    localparam logic [8:0]       Y_OFFSET    = 9'd16;
    // Rounding term plus the 128 offset moved ahead of the shift.
    localparam logic [SUM_W-1:0] CHROMA_BIAS = 17'd32896;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [ROW_W-1:0] pixel_row;
        logic [COL_W-1:0] pixel_column;
    } in_item_t;

    typedef struct packed {
        logic [7:0]        luma;
        logic [LOFF_W-1:0] luma_offset;
        logic              chroma_valid;
        logic [7:0]        blue_diff;
        logic [7:0]        red_diff;
        logic [COFF_W-1:0] blue_diff_offset;
        logic [COFF_W-1:0] red_diff_offset;
        logic              out_of_frame;
    } out_item_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pipe_en_t;

    typedef struct packed {
        logic oof;
        logic chroma;
    } pix_flags_t;

    function automatic logic [7:0] clamp_byte(input logic [8:0] v);
        logic [7:0] res;
        res = v[8] ? 8'hff : v[7:0];
        return res;
    endfunction

endpackage

FILE: src/rgb2i420_converter.sv
// Top level of the RGB565 to planar I420 pixel converter.
//
//   Port group   Direction  Handshake          Carries
//   s_*          in         s_valid/s_ready    one RGB565 pixel with row and column
//   m_*          out        m_valid/m_ready    luma, chroma and plane offsets
//   cfg_*        in         cfg_wr_en          image width and height writes
//
// Every pixel passes three register stages, and one pixel can be taken on every
// clock while the result side does not stall the pipeline.
// Reset restores a 320 by 240 frame and empties the pipeline.
// A stall on the result side holds each stage only while the stage after it
// is full, so bubbles close up and input keeps flowing until the pipeline fills.
module rgb565_to_i420_converter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  rgb2i420_pkg::in_item_t               s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output rgb2i420_pkg::out_item_t              m_data,
    input  logic                                 cfg_wr_en,
    input  logic [rgb2i420_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rgb2i420_pkg::CFG_W-1:0]       cfg_wdata
);
    import rgb2i420_pkg::*;

    logic [CFG_W-1:0] image_width_reg, image_width_next;
    logic [CFG_W-1:0] image_height_reg, image_height_next;
    pipe_en_t         en;
    pix_flags_t       flags_s2;

    always_comb begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_next  = cfg_wdata;
                REG_IMAGE_HEIGHT: image_height_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end else begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    rgb2i420_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .en      (en)
    );

    rgb2i420_color u_color (
        .aclk      (aclk),
        .en        (en),
        .pixel     (s_data.pixel),
        .flags_s2  (flags_s2),
        .luma      (m_data.luma),
        .blue_diff (m_data.blue_diff),
        .red_diff  (m_data.red_diff)
    );

    rgb2i420_addr u_addr (
        .aclk             (aclk),
        .en               (en),
        .pixel_row        (s_data.pixel_row),
        .pixel_column     (s_data.pixel_column),
        .image_width      (image_width_reg),
        .image_height     (image_height_reg),
        .flags_s2         (flags_s2),
        .luma_offset      (m_data.luma_offset),
        .chroma_valid     (m_data.chroma_valid),
        .blue_diff_offset (m_data.blue_diff_offset),
        .red_diff_offset  (m_data.red_diff_offset),
        .out_of_frame     (m_data.out_of_frame)
    );

endmodule

FILE: src/rgb2i420_ctrl.sv
// Valid tracking and per-stage advance enables for the three-stage pipeline.
module rgb2i420_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rgb2i420_pkg::pipe_en_t en
);
    import rgb2i420_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;

    always_comb begin
        en.s3   = !v3_reg || m_ready;
        en.s2   = !v2_reg || en.s3;
        en.s1   = !v1_reg || en.s2;
        v1_next = en.s1 ? s_valid : v1_reg;
        v2_next = en.s2 ? v1_reg  : v2_reg;
        v3_next = en.s3 ? v2_reg  : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign s_ready = en.s1;
    assign m_valid = v3_reg;

endmodule

FILE: src/rgb2i420_color.sv
// Color pipeline: channel expansion, BT.601 sums, shift and clamp, zero masking.
module rgb2i420_color (
    input  logic                                aclk,
    input  rgb2i420_pkg::pipe_en_t              en,
    input  logic [rgb2i420_pkg::PIX_W-1:0]      pixel,
    input  rgb2i420_pkg::pix_flags_t            flags_s2,
    output logic [7:0]                          luma,
    output logic [7:0]                          blue_diff,
    output logic [7:0]                          red_diff
);
    import rgb2i420_pkg::*;

    logic [SUM_W-1:0] r, g, b;
    logic [SUM_W-1:0] y_sum_reg, u_sum_reg, v_sum_reg;
    logic [SUM_W-1:0] y_sum_next, u_sum_next, v_sum_next;
    logic [7:0] y_reg, u_reg, v_reg;
    logic [7:0] y_next, u_next, v_next;
    logic [7:0] luma_reg, blue_reg, red_reg;
    logic [7:0] luma_next, blue_next, red_next;

    always_comb begin
        r = SUM_W'({pixel[15:11], 3'b000});
        g = SUM_W'({pixel[10:5], 2'b00});
        b = SUM_W'({pixel[4:0], 3'b000});
        y_sum_next = COEF_YR * r + COEF_YG * g + COEF_YB * b + Y_ROUND;
        u_sum_next = COEF_UB * b + CHROMA_BIAS - COEF_UR * r - COEF_UG * g;
        v_sum_next = COEF_VR * r + CHROMA_BIAS - COEF_VG * g - COEF_VB * b;
    end

    always_comb begin
        y_next = clamp_byte(9'(y_sum_reg[16:8]) + Y_OFFSET);
        u_next = clamp_byte(u_sum_reg[16:8]);
        v_next = clamp_byte(v_sum_reg[16:8]);
    end

    always_comb begin
        luma_next = flags_s2.oof ? 8'd0 : y_reg;
        blue_next = (flags_s2.oof || !flags_s2.chroma) ? 8'd0 : u_reg;
        red_next  = (flags_s2.oof || !flags_s2.chroma) ? 8'd0 : v_reg;
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            y_sum_reg <= y_sum_next;
            u_sum_reg <= u_sum_next;
            v_sum_reg <= v_sum_next;
        end
        if (en.s2) begin
            y_reg <= y_next;
            u_reg <= u_next;
            v_reg <= v_next;
        end
        if (en.s3) begin
            luma_reg <= luma_next;
            blue_reg <= blue_next;
            red_reg  <= red_next;
        end
    end

    assign luma      = luma_reg;
    assign blue_diff = blue_reg;
    assign red_diff  = red_reg;

endmodule

FILE: src/rgb2i420_addr.sv
// Address pipeline: frame check, plane offsets and chroma site flags.
module rgb2i420_addr (
    input  logic                                aclk,
    input  rgb2i420_pkg::pipe_en_t              en,
    input  logic [rgb2i420_pkg::ROW_W-1:0]      pixel_row,
    input  logic [rgb2i420_pkg::COL_W-1:0]      pixel_column,
    input  logic [rgb2i420_pkg::CFG_W-1:0]      image_width,
    input  logic [rgb2i420_pkg::CFG_W-1:0]      image_height,
    output rgb2i420_pkg::pix_flags_t            flags_s2,
    output logic [rgb2i420_pkg::LOFF_W-1:0]     luma_offset,
    output logic                                chroma_valid,
    output logic [rgb2i420_pkg::COFF_W-1:0]     blue_diff_offset,
    output logic [rgb2i420_pkg::COFF_W-1:0]     red_diff_offset,
    output logic                                out_of_frame
);
    import rgb2i420_pkg::*;

    logic [CFG_W-1:0]  w, h;
    pix_flags_t        flags1_reg, flags1_next, flags2_reg;
    logic [PROD_W-1:0] row_w_reg, row_w_next;
    logic [PROD_W-1:0] lsize1_reg, lsize1_next;
    logic [PROD_W-1:0] cmul_reg, cmul_next;
    logic [COL_W-1:0]  col_reg;
    logic [LOFF_W-1:0] loff2_reg, loff2_next;
    logic [PROD_W-1:0] cidx2_reg, cidx2_next;
    logic [PROD_W-1:0] lsize2_reg;
    logic [PROD_W-1:0] vbase2_reg, vbase2_next;
    logic [LOFF_W-1:0] loff3_reg, loff3_next;
    logic [COFF_W-1:0] uoff3_reg, uoff3_next;
    logic [COFF_W-1:0] voff3_reg, voff3_next;
    logic              chroma3_reg, chroma3_next;
    logic              oof3_reg;

    always_comb begin
        w = (image_width > MAX_WIDTH) ? MAX_WIDTH : image_width;
        h = (image_height > MAX_HEIGHT) ? MAX_HEIGHT : image_height;
        flags1_next.oof    = (CFG_W'(pixel_row) >= h) || (CFG_W'(pixel_column) >= w);
        flags1_next.chroma = !pixel_row[0] && !pixel_column[0];
        row_w_next  = PROD_W'(pixel_row) * PROD_W'(w);
        lsize1_next = PROD_W'(w) * PROD_W'(h);
        cmul_next   = PROD_W'(pixel_row[ROW_W-1:1]) * PROD_W'(w[CFG_W-1:1]);
    end

    always_comb begin
        loff2_next  = LOFF_W'(row_w_reg + PROD_W'(col_reg));
        cidx2_next  = cmul_reg + PROD_W'(col_reg[COL_W-1:1]);
        vbase2_next = lsize1_reg + (lsize1_reg >> 2);
    end

    always_comb begin
        chroma3_next = !flags2_reg.oof && flags2_reg.chroma;
        loff3_next   = flags2_reg.oof ? '0 : loff2_reg;
        uoff3_next   = chroma3_next ? COFF_W'(lsize2_reg + cidx2_reg) : '0;
        voff3_next   = chroma3_next ? COFF_W'(vbase2_reg + cidx2_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            flags1_reg <= flags1_next;
            row_w_reg  <= row_w_next;
            lsize1_reg <= lsize1_next;
            cmul_reg   <= cmul_next;
            col_reg    <= pixel_column;
        end
        if (en.s2) begin
            flags2_reg <= flags1_reg;
            loff2_reg  <= loff2_next;
            cidx2_reg  <= cidx2_next;
            lsize2_reg <= lsize1_reg;
            vbase2_reg <= vbase2_next;
        end
        if (en.s3) begin
            loff3_reg   <= loff3_next;
            uoff3_reg   <= uoff3_next;
            voff3_reg   <= voff3_next;
            chroma3_reg <= chroma3_next;
            oof3_reg    <= flags2_reg.oof;
        end
    end

    assign flags_s2         = flags2_reg;
    assign luma_offset      = loff3_reg;
    assign chroma_valid     = chroma3_reg;
    assign blue_diff_offset = uoff3_reg;
    assign red_diff_offset  = voff3_reg;
    assign out_of_frame     = oof3_reg;

endmodule
